// ----- hdl/rgb_tone_curve_lut_mapper_assert.svh -----
// Assertion macros for the tone curve mapper.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef RGB_TONE_CURVE_LUT_MAPPER_ASSERT_SVH
`define RGB_TONE_CURVE_LUT_MAPPER_ASSERT_SVH

// Condition holds in the same cycle as the trigger
`define TCLM_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition holds in the cycle after the trigger
`define TCLM_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/tclm_pkg.sv -----
// Shared types, codes and helper functions of the tone curve mapper.
// No dependencies; imported by tclm_channel and the top level.
`default_nettype none

package tclm_pkg;

   localparam int NUM_CURVES = 3;
   localparam int NUM_PARAMS = 10;
   localparam int PIPE_DEPTH = 10;

   // item commands
   localparam logic [1:0] CMD_PIXEL = 2'd0;
   localparam logic [1:0] CMD_TABLE = 2'd1;
   localparam logic [1:0] CMD_PARAM = 2'd2;

   // channel parameter selects
   localparam logic [3:0] PAR_START     = 4'd0;
   localparam logic [3:0] PAR_SCALE     = 4'd1;
   localparam logic [3:0] PAR_BLACK     = 4'd2;
   localparam logic [3:0] PAR_GAIN      = 4'd3;
   localparam logic [3:0] PAR_IN_SLOPE  = 4'd4;
   localparam logic [3:0] PAR_OUT_SLOPE = 4'd5;
   localparam logic [3:0] PAR_IN_STEEP  = 4'd6;
   localparam logic [3:0] PAR_OUT_STEEP = 4'd7;
   localparam logic [3:0] PAR_FLAGS     = 4'd8;
   localparam logic [3:0] PAR_END       = 4'd9;

   // flag bit positions
   localparam int FLG_EXTRAP    = 0;
   localparam int FLG_STEEP_IN  = 1;
   localparam int FLG_STEEP_OUT = 2;

   typedef enum logic [1:0] {
      RGN_INTERP,
      RGN_IN,
      RGN_OUT,
      RGN_ZERO
   } region_type;

   typedef struct packed {
      logic signed [31:0] start;
      logic signed [31:0] scale;
      logic signed [31:0] black;
      logic signed [31:0] gain;
      logic signed [31:0] in_slope;
      logic signed [31:0] out_slope;
      logic signed [31:0] in_steep;
      logic signed [31:0] out_steep;
      logic        [31:0] flags;
      logic signed [31:0] end_pos;
   } chan_par_type;

   // saturate to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -68'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // pack a fixed point value to a byte: clamp at zero, round 255*v, cap
   function automatic logic [7:0] to_byte(input logic signed [31:0] v, input int frac);
      logic signed [40:0] p;
      logic signed [40:0] r;
      logic [7:0]         b;
      p = (41'(v) <<< 8) - 41'(v);
      r = (p + (41'sd1 <<< (frac - 1))) >>> frac;
      if (v <= 32'sd0) begin
         b = 8'd0;
      end else if (r > 41'sd255) begin
         b = 8'd255;
      end else begin
         b = r[7:0];
      end
      return b;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/tclm_curve_mem.sv -----
// Curve table memory: one write port, two registered read ports.
// Depends on nothing outside this file.
`default_nettype none

module tclm_curve_mem #(
   parameter int DEPTH = 257,
   parameter int AW    = 9
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic signed [31:0]   wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AW-1:0]        rd_addr_a,
   input  wire logic [AW-1:0]        rd_addr_b,
   output logic signed [31:0]        rd_data_a,
   output logic signed [31:0]        rd_data_b
);

   logic signed [31:0] mem_ff [DEPTH];

   // write entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read two entries, hold on stall
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tclm_channel.sv -----
// One colour channel datapath: black/gain, table position, curve lookup,
// interpolation or extrapolation, byte packing. Uses tclm_pkg, tclm_curve_mem.
`default_nettype none

module tclm_channel
   import tclm_pkg::*;
#(
   parameter int TABLE_SIZE = 256,
   parameter int FRAC_BITS  = 16,
   parameter int AW         = $clog2(TABLE_SIZE + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 adv,
   input  wire logic                 bypass,
   input  wire logic signed [31:0]   sample,
   input  wire chan_par_type         par,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic signed [31:0]   wr_data,
   output logic [7:0]                byte_q
);

   localparam int                      F      = FRAC_BITS;
   localparam int                      IW     = F + 35;
   localparam logic signed [65:0]      Half66 = 66'sd1 <<< (F - 1);
   localparam logic signed [IW-1:0]    HalfI  = IW'(1) <<< (F - 1);
   localparam logic signed [65:0]      PosLim = 66'(TABLE_SIZE) <<< F;
   localparam logic [AW-1:0]           TopIdx = AW'(TABLE_SIZE);
   localparam logic [F:0]              One    = (F + 1)'(1) << F;

   // stage registers
   logic signed [32:0]   d_ff, d_in;
   logic                 byp_ff;
   logic signed [64:0]   prod_ff, prod_in;
   logic signed [31:0]   fac_ff, fac_in;
   logic signed [32:0]   dxs_ff, dxs_in, dxe_ff, dxe_in;
   logic                 les4_ff, ges4_ff, les5_ff, ges5_ff;
   logic signed [64:0]   pprod_ff, islp_ff, oslp_ff;
   region_type           rgn6_ff, rgn6_in, rgn7_ff, rgn8_ff;
   logic [AW-1:0]        addr_a_ff, addr_a_in, addr_b_ff, addr_b_in;
   logic [F-1:0]         f6_ff, f7_ff;
   logic signed [65:0]   sr6_ff, sr6_in, sr7_ff, sr8_ff;
   logic signed [31:0]   q_a, q_b;
   logic signed [F+33:0] m0_ff, m0_in, m1_ff, m1_in;
   logic signed [31:0]   ta8_ff;
   logic signed [31:0]   y_ff, y_in;
   logic [7:0]           byte_ff;

   logic signed [65:0]   pos, isr, osr;
   logic [AW-1:0]        idx;
   logic                 out_rng;
   logic [F:0]           wa;
   logic signed [IW-1:0] isum;
   logic signed [IW-1:0] iround;

   // subtract black, scale by gain (both skipped on bypass), offsets from start and end
   always_comb begin
      d_in    = bypass ? 33'(sample) : 33'(sample) - 33'(par.black);
      prod_in = byp_ff ? (65'(d_ff) <<< F) : d_ff * par.gain;
      fac_in  = sat32(68'((66'(prod_ff) + Half66) >>> F));
      dxs_in  = 33'(fac_ff) - 33'(par.start);
      dxe_in  = 33'(fac_ff) - 33'(par.end_pos);
   end

   // table position, region and read addresses
   always_comb begin
      pos     = (66'(pprod_ff) + Half66) >>> F;
      isr     = (66'(islp_ff) + Half66) >>> F;
      osr     = (66'(oslp_ff) + Half66) >>> F;
      out_rng = pos[65] || (pos > PosLim);
      idx     = pos[F +: AW];
      if (!out_rng) begin
         rgn6_in   = RGN_INTERP;
         addr_a_in = idx;
      end else if (les5_ff) begin
         rgn6_in   = RGN_IN;
         addr_a_in = '0;
      end else if (ges5_ff) begin
         rgn6_in   = RGN_OUT;
         addr_a_in = TopIdx;
      end else begin
         rgn6_in   = RGN_ZERO;
         addr_a_in = '0;
      end
      addr_b_in = (addr_a_in == TopIdx) ? TopIdx : addr_a_in + AW'(1);
      sr6_in    = les5_ff ? isr : osr;
   end

   // interpolation weights
   always_comb begin
      wa    = One - {1'b0, f7_ff};
      m0_in = $signed({1'b0, wa}) * q_a;
      m1_in = $signed({2'b00, f7_ff}) * q_b;
   end

   // pick curve result
   always_comb begin
      isum   = IW'(m0_ff) + IW'(m1_ff) + HalfI;
      iround = isum >>> F;
      unique case (rgn8_ff)
         RGN_INTERP: y_in = sat32(68'(iround));
         RGN_IN: begin
            if (!par.flags[FLG_EXTRAP]) begin
               y_in = ta8_ff;
            end else if (par.flags[FLG_STEEP_IN]) begin
               y_in = sat32(68'(ta8_ff) + 68'(par.in_steep));
            end else begin
               y_in = sat32(68'(ta8_ff) + 68'(sr8_ff));
            end
         end
         RGN_OUT: begin
            if (!par.flags[FLG_EXTRAP]) begin
               y_in = ta8_ff;
            end else if (par.flags[FLG_STEEP_OUT]) begin
               y_in = sat32(68'(ta8_ff) - 68'(par.out_steep));
            end else begin
               y_in = sat32(68'(ta8_ff) + 68'(sr8_ff));
            end
         end
         default: y_in = 32'sd0;
      endcase
   end

   // advance all stages together, hold on stall
   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff      <= d_in;
         byp_ff    <= bypass;
         prod_ff   <= prod_in;
         fac_ff    <= fac_in;
         dxs_ff    <= dxs_in;
         dxe_ff    <= dxe_in;
         les4_ff   <= (dxs_in <= 33'sd0);
         ges4_ff   <= (dxe_in >= 33'sd0);
         pprod_ff  <= dxs_ff * par.scale;
         islp_ff   <= par.in_slope * dxs_ff;
         oslp_ff   <= par.out_slope * dxe_ff;
         les5_ff   <= les4_ff;
         ges5_ff   <= ges4_ff;
         rgn6_ff   <= rgn6_in;
         addr_a_ff <= addr_a_in;
         addr_b_ff <= addr_b_in;
         f6_ff     <= pos[F-1:0];
         sr6_ff    <= sr6_in;
         rgn7_ff   <= rgn6_ff;
         f7_ff     <= f6_ff;
         sr7_ff    <= sr6_ff;
         m0_ff     <= m0_in;
         m1_ff     <= m1_in;
         ta8_ff    <= q_a;
         rgn8_ff   <= rgn7_ff;
         sr8_ff    <= sr7_ff;
         y_ff      <= y_in;
         byte_ff   <= to_byte(y_ff, F);
      end
   end

   tclm_curve_mem #(
      .DEPTH (TABLE_SIZE + 1),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (adv),
      .rd_addr_a (addr_a_ff),
      .rd_addr_b (addr_b_ff),
      .rd_data_a (q_a),
      .rd_data_b (q_b)
   );

   assign byte_q = byte_ff;

endmodule

`default_nettype wire

// ----- hdl/rgb_tone_curve_lut_mapper.sv -----
// Top level of the per-channel tone curve mapper: handshakes, parameter
// registers, valid line. Uses tclm_pkg, tclm_channel, assertion macros.
//
//   channel  | ports                         | moves
//   ---------+-------------------------------+---------------------------------
//   req      | req_valid/req_ready + fields  | pixel, table write, param write
//   rsp      | rsp_valid/rsp_ready + bytes   | one mapped pixel per pixel item
//   csr      | csr_valid/csr_ready + value   | pixel_channels register
//
// Pixels: one item per cycle while the output is not stalled; ten register
// stages, the first loaded at acceptance and the last driving rsp_valid; the
// curve memory read sits in stage seven.
// Table and parameter writes are taken once the pipeline has drained
// and take effect at once; they give no result.
// A stalled output freezes every stage. Synchronous reset clears the
// valid line, parameters (to zero) and pixel_channels (to 4).
`default_nettype none
`include "rgb_tone_curve_lut_mapper_assert.svh"

module rgb_tone_curve_lut_mapper
   import tclm_pkg::*;
#(
   parameter int TABLE_SIZE = 256,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_command,
   input  wire logic [1:0]                         req_channel,
   input  wire logic [$clog2(TABLE_SIZE+1)-1:0]    req_entry_index,
   input  wire logic [3:0]                         req_param_select,
   input  wire logic signed [31:0]                 req_write_value,
   input  wire logic signed [31:0]                 req_red,
   input  wire logic signed [31:0]                 req_green,
   input  wire logic signed [31:0]                 req_blue,
   input  wire logic signed [31:0]                 req_alpha,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [7:0]                              rsp_out_red,
   output logic [7:0]                              rsp_out_green,
   output logic [7:0]                              rsp_out_blue,
   output logic [7:0]                              rsp_out_alpha,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [2:0]                         csr_pixel_channels
);

   localparam int AW = $clog2(TABLE_SIZE + 1);

   logic [2:0]         pch_ff;
   logic signed [31:0] par_ff [NUM_CURVES][NUM_PARAMS];
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic               grey_ff  [PIPE_DEPTH];
   logic               force_ff [PIPE_DEPTH];
   logic [7:0]         abyte_ff [PIPE_DEPTH];

   logic               adv;
   logic               acc;
   logic               acc_pixel;
   logic               acc_table;
   logic               acc_param;
   logic               grey_in;
   logic               force_in;
   logic signed [31:0] samples [NUM_CURVES];
   chan_par_type       cpar [NUM_CURVES];
   logic [7:0]         cbyte [NUM_CURVES];

   // handshake and item decode
   assign adv       = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = adv && ((req_command == CMD_PIXEL) || (valid_ff == '0));
   assign acc       = req_valid && req_ready;
   assign acc_pixel = acc && (req_command == CMD_PIXEL);
   assign acc_table = acc && (req_command == CMD_TABLE) &&
                      (req_entry_index <= AW'(TABLE_SIZE));
   assign acc_param = acc && (req_command == CMD_PARAM);
   assign csr_ready = 1'b1;

   // channel count: one or two is grey, three forces alpha
   assign grey_in  = (pch_ff == 3'd1) || (pch_ff == 3'd2);
   assign force_in = (pch_ff == 3'd3);

   assign samples[0] = req_red;
   assign samples[1] = req_green;
   assign samples[2] = req_blue;

   // hold pixel_channels
   always_ff @(posedge clock) begin
      if (reset) begin
         pch_ff <= 3'd4;
      end else if (csr_valid && csr_ready) begin
         pch_ff <= csr_pixel_channels;
      end
   end

   // write channel parameters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CURVES; c++) begin
            for (int p = 0; p < NUM_PARAMS; p++) begin
               par_ff[c][p] <= '0;
            end
         end
      end else begin
         for (int c = 0; c < NUM_CURVES; c++) begin
            for (int p = 0; p < NUM_PARAMS; p++) begin
               if (acc_param && (req_channel == 2'(c)) && (req_param_select == 4'(p))) begin
                  par_ff[c][p] <= req_write_value;
               end
            end
         end
      end
   end

   // advance valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], acc_pixel};
      end
   end

   // carry mode bits and alpha byte alongside the channels
   always_ff @(posedge clock) begin
      if (adv) begin
         grey_ff[0]  <= grey_in;
         force_ff[0] <= force_in;
         abyte_ff[0] <= to_byte(req_alpha, FRAC_BITS);
         for (int s = 1; s < PIPE_DEPTH; s++) begin
            grey_ff[s]  <= grey_ff[s-1];
            force_ff[s] <= force_ff[s-1];
            abyte_ff[s] <= abyte_ff[s-1];
         end
      end
   end

   for (genvar c = 0; c < NUM_CURVES; c++) begin : g_chan
      assign cpar[c].start     = par_ff[c][PAR_START];
      assign cpar[c].scale     = par_ff[c][PAR_SCALE];
      assign cpar[c].black     = par_ff[c][PAR_BLACK];
      assign cpar[c].gain      = par_ff[c][PAR_GAIN];
      assign cpar[c].in_slope  = par_ff[c][PAR_IN_SLOPE];
      assign cpar[c].out_slope = par_ff[c][PAR_OUT_SLOPE];
      assign cpar[c].in_steep  = par_ff[c][PAR_IN_STEEP];
      assign cpar[c].out_steep = par_ff[c][PAR_OUT_STEEP];
      assign cpar[c].flags     = par_ff[c][PAR_FLAGS];
      assign cpar[c].end_pos   = par_ff[c][PAR_END];

      tclm_channel #(
         .TABLE_SIZE (TABLE_SIZE),
         .FRAC_BITS  (FRAC_BITS),
         .AW         (AW)
      ) u_chan (
         .clock   (clock),
         .adv     (adv),
         .bypass  ((c == 0) && grey_in),
         .sample  (samples[c]),
         .par     (cpar[c]),
         .wr_en   (acc_table && (req_channel == 2'(c))),
         .wr_addr (req_entry_index),
         .wr_data (req_write_value),
         .byte_q  (cbyte[c])
      );
   end

   // output selection
   assign rsp_valid     = valid_ff[PIPE_DEPTH-1];
   assign rsp_out_red   = cbyte[0];
   assign rsp_out_green = grey_ff[PIPE_DEPTH-1] ? cbyte[0] : cbyte[1];
   assign rsp_out_blue  = grey_ff[PIPE_DEPTH-1] ? cbyte[0] : cbyte[2];
   assign rsp_out_alpha = grey_ff[PIPE_DEPTH-1]  ? cbyte[0] :
                          force_ff[PIPE_DEPTH-1] ? 8'd255 : abyte_ff[PIPE_DEPTH-1];

   `TCLM_ASSERT_SAME(a_write_on_empty, req_valid && req_ready && (req_command != CMD_PIXEL), valid_ff == '0, "write item taken with pixels in flight")
   `TCLM_ASSERT_NEXT(a_stall_freezes, valid_ff[PIPE_DEPTH-1] && !rsp_ready, valid_ff == $past(valid_ff), "valid line moved during stall")
   `TCLM_ASSERT_NEXT(a_pixel_enters, req_valid && req_ready && (req_command == CMD_PIXEL), valid_ff[0], "accepted pixel missing from first stage")

endmodule

`default_nettype wire
